@@ sv/wbf_pkg.sv @@
`default_nettype none
package wbf_pkg;

    localparam int CAPACITY    = 64;
    localparam int ITEM_WIDTH  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int ACTION_W = 3;
    localparam int CNT_W    = 7;
    localparam int REQ_W    = 6;
    localparam int CACHE_W  = 7;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ITEMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 1'b1;
    localparam logic [CACHE_W-1:0]   CACHE_ITEMS_RST = 7'd32;
    localparam logic [REQ_W-1:0]     MAX_REQUEST_RST = 6'd16;

    // request action codes
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_COMMIT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DRAIN   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SKIP    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd5;

    typedef enum logic [2:0] {
        OP_RESERVE,
        OP_WRITE,
        OP_COMMIT,
        OP_DRAIN,
        OP_SKIP,
        OP_QUERY,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [ITEM_WIDTH-1:0] data;
        logic [CNT_W-1:0]      count;
    } in_item_t;

    typedef struct packed {
        logic [ITEM_WIDTH-1:0] item_out;
        logic [CNT_W-1:0]      result_count;
        logic [CNT_W-1:0]      fill;
        logic                  status;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        op_t                   op;
        logic [ITEM_WIDTH-1:0] data;
        logic [CNT_W-1:0]      count;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

endpackage
`default_nettype wire

@@ sv/watermark_bip_fifo.sv @@
`default_nettype none
// Channel    Handshake           Payload      Moves
// s_         s_valid / s_ready   s_item       one request: action, data, count
// m_         m_valid / m_ready   m_item       one result of a request
// cfg_       cfg_we              cfg_wdata    cache_items or max_request by cfg_index
//
// Requests are decoded in front and held in a two-entry queue; the back end runs one at a time.
// A single-result request is handled in the back end once the result register is free.
// A drain reads the head item from memory, then emits one item per cycle unless m_ready stalls.
// The result register takes a new result in the cycle its old one is taken.
// aresetn is synchronous, active low; the item store keeps its contents over reset.
module watermark_bip_fifo (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire wbf_pkg::in_item_t              s_item,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output wbf_pkg::out_item_t                  m_item,
    input  wire logic                           cfg_we,
    input  wire logic [wbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wbf_pkg::*;

    logic        push, pop;
    cmd_t        push_cmd, head_cmd;
    queue_stat_t q_stat;

    wbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    wbf_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    wbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
`default_nettype wire

@@ sv/wbf_front.sv @@
`default_nettype none
module wbf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire wbf_pkg::in_item_t s_item,
    input  wire wbf_pkg::queue_stat_t q_stat,
    output logic                   push,
    output wbf_pkg::cmd_t          push_cmd
);
    import wbf_pkg::*;

    op_t op;

    always_comb begin
        case (s_item.action)
            ACT_RESERVE: op = OP_RESERVE;
            ACT_WRITE:   op = OP_WRITE;
            ACT_COMMIT:  op = OP_COMMIT;
            ACT_DRAIN:   op = OP_DRAIN;
            ACT_SKIP:    op = OP_SKIP;
            ACT_QUERY:   op = OP_QUERY;
            default:     op = OP_BAD;
        endcase
    end

    assign s_ready         = ~q_stat.full;
    assign push            = s_valid & s_ready;
    assign push_cmd.op     = op;
    assign push_cmd.data   = s_item.data;
    assign push_cmd.count  = s_item.count;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push)
        else $error("request pushed into a full queue");

endmodule
`default_nettype wire

@@ sv/wbf_cmd_queue.sv @@
`default_nettype none
module wbf_cmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire wbf_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output wbf_pkg::cmd_t      head_cmd,
    output wbf_pkg::queue_stat_t q_stat
);
    import wbf_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.valid)
        else $error("pop from an empty queue");

endmodule
`default_nettype wire

@@ sv/wbf_back.sv @@
`default_nettype none
module wbf_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [wbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire wbf_pkg::cmd_t                head_cmd,
    input  wire wbf_pkg::queue_stat_t         q_stat,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output wbf_pkg::out_item_t                m_item
);
    import wbf_pkg::*;

    typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   read_pos_reg, read_pos_next;
    logic [POS_W-1:0]   right_end_reg, right_end_next;
    logic [POS_W-1:0]   left_end_reg, left_end_next;
    logic               wrapped_reg, wrapped_next;
    logic               reserved_reg, reserved_next;
    logic [POS_W-1:0]   reserve_start_reg, reserve_start_next;
    logic [REQ_W-1:0]   reserve_len_reg, reserve_len_next;
    logic [REQ_W-1:0]   write_offset_reg, write_offset_next;
    logic [CACHE_W-1:0] cache_items_reg, cache_items_next;
    logic [REQ_W-1:0]   max_request_reg, max_request_next;
    logic [POS_W-1:0]   drain_k_reg, drain_k_next;
    logic [POS_W-1:0]   drain_n_reg, drain_n_next;
    logic [POS_W-1:0]   drain_after_reg, drain_after_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic [ITEM_WIDTH-1:0] item_mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  mem_we, rd_en;
    logic [ADDR_W-1:0]     mem_waddr, rd_addr;
    logic [POS_W-1:0]      rd_k;

    logic             out_free;
    logic [POS_W-1:0] right_len, fill;
    logic [CMP_W-1:0] count_c, fill_c;

    // head advance, shared by drain and skip
    logic [POS_W-1:0] adv_n, adv_read_pos, adv_right_end, adv_fill;
    logic             adv_wrapped;

    // commit placement
    logic [POS_W-1:0] cm_n, cm_right_end, cm_left_end, cm_fill;
    logic             cm_wrapped;

    // reserve placement
    logic             rs_ok;
    logic [POS_W-1:0] rs_start;

    function automatic logic [ADDR_W-1:0] item_addr(
        input logic [POS_W-1:0] k,
        input logic [POS_W-1:0] rpos,
        input logic [POS_W-1:0] rlen,
        input logic             wrap
    );
        logic [POS_W-1:0] idx;
        idx = (wrap && (k >= rlen)) ? (k - rlen) : (rpos + k);
        item_addr = idx[ADDR_W-1:0];
    endfunction

    assign out_free  = ~out_valid_reg | m_ready;
    assign right_len = right_end_reg - read_pos_reg;
    assign fill      = right_len + (wrapped_reg ? left_end_reg : '0);
    assign count_c   = CMP_W'(head_cmd.count);
    assign fill_c    = CMP_W'(fill);

    always_comb begin
        adv_n         = (state_reg == ST_DRAIN) ? drain_n_reg : POS_W'(head_cmd.count);
        adv_read_pos  = read_pos_reg + adv_n;
        adv_right_end = right_end_reg;
        adv_wrapped   = wrapped_reg;
        if (wrapped_reg && !(right_len > adv_n)) begin
            adv_read_pos  = adv_n - right_len;
            adv_right_end = left_end_reg;
            adv_wrapped   = 1'b0;
        end
        adv_fill = adv_right_end - adv_read_pos + (adv_wrapped ? left_end_reg : '0);
    end

    always_comb begin
        cm_n = (count_c > CMP_W'(reserve_len_reg)) ? POS_W'(reserve_len_reg)
                                                   : POS_W'(head_cmd.count);
        cm_right_end = right_end_reg;
        cm_left_end  = left_end_reg;
        cm_wrapped   = wrapped_reg;
        if (cm_n != '0) begin
            if (wrapped_reg) begin
                cm_left_end = reserve_start_reg + cm_n;
            end else if (reserve_start_reg == right_end_reg) begin
                cm_right_end = right_end_reg + cm_n;
                cm_left_end  = right_end_reg + cm_n;
            end else begin
                cm_left_end = reserve_start_reg + cm_n;
                cm_wrapped  = 1'b1;
            end
        end
        cm_fill = cm_right_end - read_pos_reg + (cm_wrapped ? cm_left_end : '0);
    end

    always_comb begin
        rs_ok    = 1'b0;
        rs_start = '0;
        if (!reserved_reg && (count_c <= CMP_W'(max_request_reg))) begin
            if (wrapped_reg) begin
                if ((read_pos_reg >= left_end_reg) &&
                    (CMP_W'(read_pos_reg - left_end_reg) >= count_c)) begin
                    rs_ok    = 1'b1;
                    rs_start = left_end_reg;
                end
            end else if (CMP_W'(POS_W'(CAPACITY) - right_end_reg) >= count_c) begin
                rs_ok    = 1'b1;
                rs_start = right_end_reg;
            end else if (CMP_W'(read_pos_reg) >= count_c) begin
                rs_ok = 1'b1;
            end
        end
    end

    always_comb begin
        state_next         = state_reg;
        read_pos_next      = read_pos_reg;
        right_end_next     = right_end_reg;
        left_end_next      = left_end_reg;
        wrapped_next       = wrapped_reg;
        reserved_next      = reserved_reg;
        reserve_start_next = reserve_start_reg;
        reserve_len_next   = reserve_len_reg;
        write_offset_next  = write_offset_reg;
        cache_items_next   = cache_items_reg;
        max_request_next   = max_request_reg;
        drain_k_next       = drain_k_reg;
        drain_n_next       = drain_n_reg;
        drain_after_next   = drain_after_reg;
        out_valid_next     = out_valid_reg & ~m_ready;
        out_item_next      = out_item_reg;
        pop                = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = ADDR_W'(reserve_start_reg + POS_W'(write_offset_reg));
        rd_en              = 1'b0;
        rd_k               = (state_reg == ST_DRAIN) ? drain_k_reg + 1'b1 : '0;
        rd_addr            = item_addr(rd_k, read_pos_reg, right_len, wrapped_reg);

        if (cfg_we) begin
            case (cfg_index)
                CFG_CACHE_ITEMS: cache_items_next = cfg_wdata[CACHE_W-1:0];
                CFG_MAX_REQUEST: max_request_next = cfg_wdata[REQ_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_stat.valid && out_free) begin
                    pop                        = 1'b1;
                    out_valid_next             = 1'b1;
                    out_item_next.item_out     = '0;
                    out_item_next.result_count = '0;
                    out_item_next.fill         = CNT_W'(fill);
                    out_item_next.status       = 1'b0;
                    out_item_next.last         = 1'b1;
                    case (head_cmd.op)
                        OP_RESERVE: begin
                            out_item_next.status = ~rs_ok;
                            if (rs_ok) begin
                                reserved_next      = 1'b1;
                                reserve_start_next = rs_start;
                                reserve_len_next   = REQ_W'(head_cmd.count);
                                write_offset_next  = '0;
                            end
                        end
                        OP_WRITE: begin
                            if (reserved_reg && (write_offset_reg < reserve_len_reg)) begin
                                mem_we            = 1'b1;
                                write_offset_next = write_offset_reg + 1'b1;
                            end else begin
                                out_item_next.status = 1'b1;
                            end
                        end
                        OP_COMMIT: begin
                            if (reserved_reg) begin
                                right_end_next             = cm_right_end;
                                left_end_next              = cm_left_end;
                                wrapped_next               = cm_wrapped;
                                reserved_next              = 1'b0;
                                reserve_len_next           = '0;
                                write_offset_next          = '0;
                                out_item_next.result_count = CNT_W'(cm_n);
                                out_item_next.fill         = CNT_W'(cm_fill);
                            end else begin
                                out_item_next.status = 1'b1;
                            end
                        end
                        OP_DRAIN: begin
                            if (fill > POS_W'(cache_items_reg)) begin
                                // prefetch the head item, emit from the drain loop
                                out_valid_next   = out_valid_reg & ~m_ready;
                                out_item_next    = out_item_reg;
                                rd_en            = 1'b1;
                                drain_k_next     = '0;
                                drain_n_next     = fill - POS_W'(cache_items_reg);
                                drain_after_next = POS_W'(cache_items_reg);
                                state_next       = ST_DRAIN;
                            end
                        end
                        OP_SKIP: begin
                            if (fill_c <= count_c) begin
                                read_pos_next  = reserved_reg ? reserve_start_reg : '0;
                                right_end_next = reserved_reg ? reserve_start_reg : '0;
                                left_end_next  = '0;
                                wrapped_next   = 1'b0;
                                out_item_next.result_count = CNT_W'(fill);
                                out_item_next.fill         = '0;
                            end else begin
                                read_pos_next  = adv_read_pos;
                                right_end_next = adv_right_end;
                                wrapped_next   = adv_wrapped;
                                out_item_next.result_count = head_cmd.count;
                                out_item_next.fill         = CNT_W'(adv_fill);
                            end
                        end
                        OP_QUERY: ;
                        default: out_item_next.status = 1'b1;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_valid_next             = 1'b1;
                    out_item_next.item_out     = rd_data_reg;
                    out_item_next.result_count = CNT_W'(drain_n_reg);
                    out_item_next.fill         = CNT_W'(drain_after_reg);
                    out_item_next.status       = 1'b0;
                    out_item_next.last         = (drain_k_reg == drain_n_reg - 1'b1);
                    if (drain_k_reg == drain_n_reg - 1'b1) begin
                        read_pos_next  = adv_read_pos;
                        right_end_next = adv_right_end;
                        wrapped_next   = adv_wrapped;
                        state_next     = ST_IDLE;
                    end else begin
                        rd_en        = 1'b1;
                        drain_k_next = drain_k_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            read_pos_reg      <= '0;
            right_end_reg     <= '0;
            left_end_reg      <= '0;
            wrapped_reg       <= 1'b0;
            reserved_reg      <= 1'b0;
            reserve_start_reg <= '0;
            reserve_len_reg   <= '0;
            write_offset_reg  <= '0;
            cache_items_reg   <= CACHE_ITEMS_RST;
            max_request_reg   <= MAX_REQUEST_RST;
            drain_k_reg       <= '0;
            drain_n_reg       <= '0;
            drain_after_reg   <= '0;
            out_valid_reg     <= 1'b0;
            out_item_reg      <= '0;
        end else begin
            state_reg         <= state_next;
            read_pos_reg      <= read_pos_next;
            right_end_reg     <= right_end_next;
            left_end_reg      <= left_end_next;
            wrapped_reg       <= wrapped_next;
            reserved_reg      <= reserved_next;
            reserve_start_reg <= reserve_start_next;
            reserve_len_reg   <= reserve_len_next;
            write_offset_reg  <= write_offset_next;
            cache_items_reg   <= cache_items_next;
            max_request_reg   <= max_request_next;
            drain_k_reg       <= drain_k_next;
            drain_n_reg       <= drain_n_next;
            drain_after_reg   <= drain_after_next;
            out_valid_reg     <= out_valid_next;
            out_item_reg      <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            item_mem[mem_waddr] <= head_cmd.data;
        end
        if (rd_en) begin
            rd_data_reg <= item_mem[rd_addr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        read_pos_reg <= right_end_reg)
        else $error("read position passed the right end");

    a_wrap_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wrapped_reg |-> (left_end_reg <= read_pos_reg))
        else $error("left region overlaps the head");

    a_region_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg |-> (CMP_W'(reserve_start_reg) + CMP_W'(reserve_len_reg)
                          <= CMP_W'(CAPACITY)))
        else $error("reserved region runs past the store");

    a_drain_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (drain_k_reg < drain_n_reg))
        else $error("drain index beyond run length");

endmodule
`default_nettype wire

@@ tb/watermark_bip_fifo_test.sv @@
`timescale 1ns / 1ps
module watermark_bip_fifo_test;
    import wbf_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_BAD_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_BAD_HI = 3'd7;
    localparam int unsigned LONGEST_RUN = 64;

    typedef struct packed {
        bit                 is_cfg;
        bit                 known;
        logic [CACHE_W-1:0] cfg_cache;
        logic [REQ_W-1:0]   cfg_max;
        in_item_t           req;
        out_item_t          want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    watermark_bip_fifo uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // buffer state as the predictor sees it
    logic [ITEM_WIDTH-1:0] store_q [0:CAPACITY-1];
    bit                    written [0:CAPACITY-1];
    int unsigned rd_pos = 0, r_end = 0, l_end = 0;
    bit          wrap_q = 1'b0, res_open = 1'b0;
    int unsigned res_start = 0, res_len = 0, wr_off = 0;
    int unsigned cache_lim = CACHE_ITEMS_RST;
    int unsigned req_lim   = MAX_REQUEST_RST;

    out_item_t awaited[$];
    out_item_t step_results[$];
    out_item_t head;
    dir_row_t  plan[$];

    int mismatches = 0;
    int n_requests = 0, n_results = 0, n_rejected = 0;
    int n_drained = 0, longest_drain = 0, n_full = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("watermark_bip_fifo_test: FAIL");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned fill_now();
        int unsigned n;
        n = r_end - rd_pos;
        if (wrap_q) n += l_end;
        return n;
    endfunction

    function automatic void advance(input int unsigned n);
        int unsigned right;
        if (!wrap_q) begin
            rd_pos += n;
        end else begin
            right = r_end - rd_pos;
            if (right > n) begin
                rd_pos += n;
            end else begin
                // head moves into the left region
                rd_pos = n - right;
                r_end  = l_end;
                wrap_q = 1'b0;
            end
        end
    endfunction

    function automatic logic [ITEM_WIDTH-1:0] item_at(input int unsigned k);
        int unsigned right, idx;
        right = r_end - rd_pos;
        idx = (wrap_q && k >= right) ? k - right : rd_pos + k;
        return (idx < CAPACITY) ? store_q[idx] : '0;
    endfunction

    // largest commit count that publishes only entries written at some point
    function automatic logic [CNT_W-1:0] safe_commit(input logic [CNT_W-1:0] want);
        int unsigned n, k;
        n = (want > res_len) ? res_len : want;
        for (k = 0; k < n; k++)
            if (res_start + k >= CAPACITY || !written[res_start + k]) return k[CNT_W-1:0];
        return want;
    endfunction

    task automatic apply_request(input in_item_t req);
        out_item_t   r;
        int unsigned fill, cnt, n, start, base, idx, k, after;
        bit          ok;
        cnt  = req.count;
        fill = fill_now();
        r = '0;
        r.last = 1'b1;
        r.fill = fill[CNT_W-1:0];
        if (fill == CAPACITY) n_full++;
        case (req.action)
            ACT_RESERVE: begin
                ok = 1'b0;
                start = 0;
                if (!res_open && cnt <= req_lim) begin
                    if (wrap_q) begin
                        if (rd_pos >= l_end && rd_pos - l_end >= cnt) begin
                            start = l_end;
                            ok = 1'b1;
                        end
                    end else if (CAPACITY - r_end >= cnt) begin
                        start = r_end;
                        ok = 1'b1;
                    end else if (rd_pos >= cnt) begin
                        start = 0;
                        ok = 1'b1;
                    end
                end
                if (ok) begin
                    res_open  = 1'b1;
                    res_start = start;
                    res_len   = cnt;
                    wr_off    = 0;
                end
                r.status = !ok;
            end
            ACT_WRITE: begin
                ok = res_open && wr_off < res_len;
                if (ok) begin
                    idx = res_start + wr_off;
                    if (idx < CAPACITY) begin
                        store_q[idx] = req.data;
                        written[idx] = 1'b1;
                    end
                    wr_off++;
                end
                r.status = !ok;
            end
            ACT_COMMIT: begin
                if (!res_open) begin
                    r.status = 1'b1;
                end else begin
                    n = (cnt > res_len) ? res_len : cnt;
                    if (n > 0) begin
                        if (wrap_q) begin
                            l_end = res_start + n;
                        end else if (res_start == r_end) begin
                            r_end += n;
                            l_end = r_end;
                        end else begin
                            l_end  = res_start + n;
                            wrap_q = 1'b1;
                        end
                    end
                    res_open = 1'b0;
                    res_len  = 0;
                    wr_off   = 0;
                    after = fill_now();
                    r.result_count = n[CNT_W-1:0];
                    r.fill = after[CNT_W-1:0];
                end
            end
            ACT_DRAIN: begin
                if (fill <= cache_lim) begin
                    step_results.push_back(r);
                    return;
                end
                n = fill - cache_lim;
                if (n > LONGEST_RUN) n = LONGEST_RUN;
                after = fill - n;
                for (k = 0; k < n; k++) begin
                    r.item_out     = item_at(k);
                    r.result_count = n[CNT_W-1:0];
                    r.fill         = after[CNT_W-1:0];
                    r.last         = (k + 1 == n);
                    step_results.push_back(r);
                end
                advance(n);
                n_drained += n;
                if (n > longest_drain) longest_drain = n;
                return;
            end
            ACT_SKIP: begin
                if (fill <= cnt) begin
                    // empty the buffer, keep an open region where it is
                    base = res_open ? res_start : 0;
                    rd_pos = base;
                    r_end  = base;
                    l_end  = 0;
                    wrap_q = 1'b0;
                    r.result_count = fill[CNT_W-1:0];
                    r.fill = '0;
                end else begin
                    advance(cnt);
                    after = fill_now();
                    r.result_count = cnt[CNT_W-1:0];
                    r.fill = after[CNT_W-1:0];
                end
            end
            ACT_QUERY: ;
            default: r.status = 1'b1;
        endcase
        if (r.status) n_rejected++;
        step_results.push_back(r);
    endtask

    task automatic issue(input in_item_t req, input bit known, input out_item_t want);
        int gap;
        if (req.action == ACT_COMMIT && res_open) req.count = safe_commit(req.count);
        gap = ((n_requests / 40) % 3 == 2) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        n_requests++;
        step_results.delete();
        apply_request(req);
        if (known) awaited.push_back(want);
        else foreach (step_results[i]) awaited.push_back(step_results[i]);
    endtask

    task automatic issue_plain(input logic [ACTION_W-1:0] act, input logic [ITEM_WIDTH-1:0] d,
                               input logic [CNT_W-1:0] c);
        in_item_t req;
        req.action = act;
        req.data   = d;
        req.count  = c;
        issue(req, 1'b0, '0);
    endtask

    task automatic load_regs(input logic [CACHE_W-1:0] cache, input logic [REQ_W-1:0] maxr);
        // hold off until every result of the last phase is in
        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CACHE_ITEMS;
        cfg_wdata <= cache;
        @(posedge aclk);
        cache_lim = cache;
        cfg_index <= CFG_MAX_REQUEST;
        cfg_wdata <= {1'b0, maxr};
        @(posedge aclk);
        req_lim = maxr;
        cfg_we <= 1'b0;
    endtask

    task automatic side_request();
        int pick, fill;
        pick = $urandom_range(0, 99);
        fill = fill_now();
        if (pick < 40)
            issue_plain(ACT_DRAIN, $urandom(), CNT_W'($urandom_range(0, 64)));
        else if (pick < 65)
            issue_plain(ACT_SKIP, $urandom(), CNT_W'(($urandom_range(0, 4) == 0) ?
                        $urandom_range(0, 64) : $urandom_range(0, fill)));
        else if (pick < 80)
            issue_plain(ACT_QUERY, $urandom(), CNT_W'($urandom_range(0, 64)));
        else
            issue_plain(ACTION_W'($urandom_range(0, 7)), $urandom(),
                        CNT_W'($urandom_range(0, 64)));
    endtask

    task automatic random_phase(input int quota);
        int target, k, w;
        target = n_requests + quota;
        while (n_requests < target) begin
            if ($urandom_range(0, 99) < 60) begin
                if (!res_open) begin
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, req_lim);
                    issue_plain(ACT_RESERVE, $urandom(), CNT_W'(k));
                end
                if (res_open) begin
                    w = res_len - wr_off;
                    case ($urandom_range(0, 7))
                        0: w = $urandom_range(0, w);
                        1: w = w + 1;
                        default: ;
                    endcase
                    repeat (w) begin
                        if ($urandom_range(0, 9) == 0) side_request();
                        issue_plain(ACT_WRITE, $urandom(), CNT_W'($urandom_range(0, 64)));
                    end
                    k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 64) : res_len;
                    issue_plain(ACT_COMMIT, $urandom(), CNT_W'(k));
                end
            end else begin
                side_request();
            end
        end
    endtask

    function automatic dir_row_t req_row(input logic [ACTION_W-1:0] act,
                                         input logic [ITEM_WIDTH-1:0] d,
                                         input logic [CNT_W-1:0] c);
        dir_row_t row;
        row = '0;
        row.req.action = act;
        row.req.data   = d;
        row.req.count  = c;
        return row;
    endfunction

    function automatic dir_row_t checked_row(input logic [ACTION_W-1:0] act,
                                             input logic [ITEM_WIDTH-1:0] d,
                                             input logic [CNT_W-1:0] c,
                                             input logic [CNT_W-1:0] rc,
                                             input logic [CNT_W-1:0] fl,
                                             input logic st);
        dir_row_t row;
        row = req_row(act, d, c);
        row.known = 1'b1;
        row.want.result_count = rc;
        row.want.fill   = fl;
        row.want.status = st;
        row.want.last   = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CACHE_W-1:0] cache,
                                         input logic [REQ_W-1:0] maxr);
        dir_row_t row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_cache = cache;
        row.cfg_max   = maxr;
        return row;
    endfunction

    // result side: stall per result, with runs of no stall
    initial begin : result_ready
        int gap, n_taken;
        n_taken = 0;
        m_ready = 1'b0;
        forever begin
            gap = ((n_taken / 32) % 3 == 1) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            n_taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (awaited.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with none pending: %h",
                                        n_results, m_item));
            end else begin
                head = awaited.pop_front();
                if (m_item.item_out !== head.item_out)
                    note_mismatch($sformatf("result %0d item_out %h, want %h",
                                            n_results, m_item.item_out, head.item_out));
                if (m_item.result_count !== head.result_count)
                    note_mismatch($sformatf("result %0d result_count %0d, want %0d",
                                            n_results, m_item.result_count, head.result_count));
                if (m_item.fill !== head.fill)
                    note_mismatch($sformatf("result %0d fill %0d, want %0d",
                                            n_results, m_item.fill, head.fill));
                if (m_item.status !== head.status)
                    note_mismatch($sformatf("result %0d status %b, want %b",
                                            n_results, m_item.status, head.status));
                if (m_item.last !== head.last)
                    note_mismatch($sformatf("result %0d last %b, want %b",
                                            n_results, m_item.last, head.last));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // reset register values first
        plan.push_back(checked_row(ACT_QUERY,   32'h0, 7'd0,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_DRAIN,   32'h0, 7'd0,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_WRITE,   32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_COMMIT,  32'h0, 7'd64, 7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_RESERVE, 32'h0, 7'd17, 7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_BAD_HI,  32'hFFFF_FFFF, 7'd64, 7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_BAD_LO,  32'h0, 7'd0,  7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_RESERVE, 32'h0, 7'd2,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_RESERVE, 32'h0, 7'd1,  7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_WRITE,   32'h0, 7'd0,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_WRITE,   32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_WRITE,   32'hA5A5_A5A5, 7'd0, 7'd0, 7'd0, 1'b1));
        plan.push_back(checked_row(ACT_COMMIT,  32'h0, 7'd64, 7'd2, 7'd2, 1'b0));
        plan.push_back(checked_row(ACT_DRAIN,   32'h0, 7'd0,  7'd0, 7'd2, 1'b0));
        plan.push_back(reg_row(7'd0, 6'd32));
        plan.push_back(checked_row(ACT_RESERVE, 32'h0, 7'd32, 7'd0, 7'd2, 1'b0));
        plan.push_back(checked_row(ACT_WRITE,   32'h1234_5678, 7'd0, 7'd0, 7'd2, 1'b0));
        // drain and skip while a region is open
        plan.push_back(req_row(ACT_DRAIN, 32'h0, 7'd0));
        plan.push_back(req_row(ACT_SKIP,  32'h0, 7'd0));
        plan.push_back(checked_row(ACT_COMMIT,  32'h0, 7'd0,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_SKIP,    32'h0, 7'd64, 7'd0, 7'd0, 1'b0));
        // publish one stale entry next to a fresh one
        plan.push_back(checked_row(ACT_RESERVE, 32'h0, 7'd2,  7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_WRITE,   32'hDEAD_BEEF, 7'd0, 7'd0, 7'd0, 1'b0));
        plan.push_back(checked_row(ACT_COMMIT,  32'h0, 7'd2,  7'd2, 7'd2, 1'b0));
        plan.push_back(req_row(ACT_DRAIN, 32'h0, 7'd0));
        plan.push_back(checked_row(ACT_QUERY,   32'h0, 7'd0,  7'd0, 7'd0, 1'b0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) load_regs(plan[i].cfg_cache, plan[i].cfg_max);
            else issue(plan[i].req, plan[i].known, plan[i].want);
        end

        load_regs(CACHE_ITEMS_RST, MAX_REQUEST_RST);
        random_phase(40);
        load_regs(7'd64, 6'd32);
        random_phase(40);
        load_regs(7'd0, 6'd1);
        random_phase(30);
        load_regs(CACHE_W'($urandom_range(0, 64)), REQ_W'($urandom_range(1, 32)));
        random_phase(40);
        load_regs(7'd0, 6'd32);
        random_phase(40);

        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("summary: %0d requests, %0d results checked, %0d rejected",
                 n_requests, n_results, n_rejected);
        $display("summary: %0d items drained, longest drain %0d, full buffer seen %0d times",
                 n_drained, longest_drain, n_full);
        if (mismatches == 0) begin
            $display("watermark_bip_fifo_test: PASS");
        end else begin
            $display("watermark_bip_fifo_test: FAIL");
        end
        $finish;
    end

endmodule
